FILE: rtl/gcfa_pkg.sv
// ----------------------------------------------------------------------------
// gcfa_pkg
// Shared types and constants of the greedy capacity fill allocator.
// ----------------------------------------------------------------------------
package gcfa_pkg;

  localparam int NUM_FAC = 16;
  localparam int IDX_W   = 4;
  localparam int FAC_W   = 5;
  localparam int QTY_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int QDEPTH  = 2;

  // facility code carried by a shortfall result
  localparam logic [FAC_W-1:0] SHORT_FAC = FAC_W'(NUM_FAC);
  localparam logic [FAC_W-1:0] ACT_RST   = FAC_W'(NUM_FAC);

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DEMAND = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] load_index;
    logic [QTY_W-1:0] load_capacity;
    logic [QTY_W-1:0] demand;
    logic             last_in_period;
  } in_item_t;

  typedef struct packed {
    logic [FAC_W-1:0]  facility;
    logic [QTY_W-1:0]  share_amount;
    logic [FRAC_W:0]   share_fraction;
    logic              shortfall;
    logic              last_share;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_DEMAND  = 2'd1,
    KIND_RESTORE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] idx;
    logic [QTY_W-1:0] value;
    logic             last;
  } q_entry_t;

endpackage

FILE: rtl/greedy_capacity_fill_allocator.sv
// ----------------------------------------------------------------------------
// greedy_capacity_fill_allocator
// Northwest-corner allocator: demands are filled from facility capacities in
// order, one word per facility share with its Q1.16 fraction of the demand.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item): mode 0 words load one
// facility capacity, mode 1 words carry one customer demand. A demand with
// last_in_period set restores full capacities after it is served.
// Result channel (out_valid / out_stall / out_item): one word per share, the
// final one of a demand flagged by last_share; a shortfall word (facility 16)
// carries any unmet rest. A zero demand gives no word.
// cfg_we / cfg_wdata set the number of usable facilities; write only when idle.
// A two-word queue sits in front of the allocation engine. A demand takes one
// scan step per facility visited, and each emitted share adds one scan step,
// 17 divider steps and one output load; the fraction divider gives one bit
// per cycle.
// Reset clears all capacities, the fill position and the queue and sets the
// facility count to 16. A stalled result word holds; the engine then waits
// with its next share while the queue keeps taking input until it is full.
// ----------------------------------------------------------------------------
module greedy_capacity_fill_allocator
  import gcfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [FAC_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_item;

  gcfa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  gcfa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/gcfa_front.sv
// ----------------------------------------------------------------------------
// gcfa_front
// Accepts input words, sorts them into load, demand or restore commands and
// holds them in a short queue for the allocation engine.
// ----------------------------------------------------------------------------
module gcfa_front
  import gcfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  output q_entry_t q_item,
  input  logic     q_pop
);

  q_entry_t       ent;
  logic           keep;
  logic           push;
  q_entry_t       buf_r [QDEPTH];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  always_comb begin
    ent.idx  = in_item.load_index;
    ent.last = in_item.last_in_period;
    keep     = 1'b1;
    if (in_item.mode == MODE_LOAD) begin
      ent.kind  = KIND_LOAD;
      ent.value = in_item.load_capacity;
    end else begin
      ent.value = in_item.demand;
      if (in_item.demand != '0) begin
        ent.kind = KIND_DEMAND;
      end else begin
        // zero demand only matters when it closes the period
        ent.kind = KIND_RESTORE;
        keep     = in_item.last_in_period;
      end
    end
  end

  assign in_stall = (count_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count_r != '0);
  assign q_item   = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= ent;
    end
  end

endmodule

FILE: rtl/gcfa_back.sv
// ----------------------------------------------------------------------------
// gcfa_back
// Allocation engine: holds the capacity table and fill position, walks the
// facilities for each demand and divides each share into a Q1.16 fraction.
// ----------------------------------------------------------------------------
module gcfa_back
  import gcfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [FAC_W-1:0] cfg_wdata,
  input  logic             q_valid,
  input  q_entry_t         q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  localparam int CNT_W = $clog2(FRAC_W + 1);

  state_t            state_r, state_nxt;
  logic [QTY_W-1:0]  cap_r [NUM_FAC];
  logic              cap_we;
  logic [IDX_W-1:0]  cap_widx;
  logic [FAC_W-1:0]  act_r;
  logic [FAC_W-1:0]  cur_r, cur_nxt;
  logic [QTY_W-1:0]  resid_r, resid_nxt;
  logic [QTY_W-1:0]  dem_r, dem_nxt;
  logic [QTY_W-1:0]  rest_r, rest_nxt;
  logic              plast_r, plast_nxt;
  logic [FAC_W-1:0]  fac_r, fac_nxt;
  logic [QTY_W-1:0]  amt_r, amt_nxt;
  logic              sf_r, sf_nxt;
  logic              fin_r, fin_nxt;
  logic [QTY_W-1:0]  rem_r, rem_nxt;
  logic [FRAC_W:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              out_free;
  logic [FAC_W-1:0]  lim;
  logic [FAC_W-1:0]  cur_inc;
  logic [QTY_W-1:0]  cap_next;
  logic [QTY_W:0]    shifted;
  logic [QTY_W:0]    diff;
  logic              ge;

  assign lim      = (act_r > FAC_W'(NUM_FAC)) ? FAC_W'(NUM_FAC) : act_r;
  assign cur_inc  = cur_r + 1'b1;
  assign cap_next = (cur_inc < FAC_W'(NUM_FAC)) ? cap_r[cur_inc[IDX_W-1:0]] : '0;
  assign out_free = !out_vld_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  // one restoring division step per cycle, first step without shift
  assign shifted = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, dem_r};
  assign ge      = (shifted >= {1'b0, dem_r});

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    resid_nxt   = resid_r;
    dem_nxt     = dem_r;
    rest_nxt    = rest_r;
    plast_nxt   = plast_r;
    fac_nxt     = fac_r;
    amt_nxt     = amt_r;
    sf_nxt      = sf_r;
    fin_nxt     = fin_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    cnt_nxt     = cnt_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && out_stall;
    cap_we      = 1'b0;
    cap_widx    = q_item.idx;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.kind)
            KIND_LOAD: begin
              if ({1'b0, q_item.idx} < FAC_W'(NUM_FAC)) begin
                cap_we = 1'b1;
                if ({1'b0, q_item.idx} == cur_r) begin
                  resid_nxt = q_item.value;
                end
              end
            end
            KIND_DEMAND: begin
              dem_nxt   = q_item.value;
              rest_nxt  = q_item.value;
              plast_nxt = q_item.last;
              state_nxt = ST_SCAN;
            end
            KIND_RESTORE: begin
              cur_nxt   = '0;
              resid_nxt = cap_r[0];
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = '0;
        if (cur_r < lim) begin
          if (resid_r > rest_r) begin
            fac_nxt   = cur_r;
            amt_nxt   = rest_r;
            sf_nxt    = 1'b0;
            fin_nxt   = 1'b1;
            rem_nxt   = rest_r;
            resid_nxt = resid_r - rest_r;
            rest_nxt  = '0;
            state_nxt = ST_DIV;
          end else begin
            if (resid_r != '0) begin
              fac_nxt   = cur_r;
              amt_nxt   = resid_r;
              sf_nxt    = 1'b0;
              fin_nxt   = (resid_r == rest_r);
              rem_nxt   = resid_r;
              rest_nxt  = rest_r - resid_r;
              state_nxt = ST_DIV;
            end
            // facility used up or empty, move on
            cur_nxt   = cur_inc;
            resid_nxt = cap_next;
          end
        end else begin
          fac_nxt   = SHORT_FAC;
          amt_nxt   = rest_r;
          sf_nxt    = 1'b1;
          fin_nxt   = 1'b1;
          rem_nxt   = rest_r;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? diff[QTY_W-1:0] : shifted[QTY_W-1:0];
        quo_nxt = {quo_r[FRAC_W-1:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAC_W)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_nxt.facility       = fac_r;
          out_nxt.share_amount   = amt_r;
          out_nxt.share_fraction = quo_r;
          out_nxt.shortfall      = sf_r;
          out_nxt.last_share     = fin_r;
          out_vld_nxt            = 1'b1;
          if (fin_r) begin
            state_nxt = ST_IDLE;
            if (plast_r) begin
              cur_nxt   = '0;
              resid_nxt = cap_r[0];
            end
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      act_r     <= ACT_RST;
      cur_r     <= '0;
      resid_r   <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < NUM_FAC; i++) begin
        cap_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      resid_r   <= resid_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        act_r <= cfg_wdata;
      end
      if (cap_we) begin
        cap_r[cap_widx] <= q_item.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    dem_r   <= dem_nxt;
    rest_r  <= rest_nxt;
    plast_r <= plast_nxt;
    fac_r   <= fac_nxt;
    amt_r   <= amt_nxt;
    sf_r    <= sf_nxt;
    fin_r   <= fin_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= FAC_W'(NUM_FAC))
    else $error("fill position past the facility count");

  a_scan_rest: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> rest_r != '0)
    else $error("scanning with nothing left to serve");

  a_share_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> (amt_r != '0) && (amt_r <= dem_r))
    else $error("share amount outside the demand");

  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && sf_r |-> fin_r && (fac_r == SHORT_FAC))
    else $error("shortfall word not marked final");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (cnt_r != '0) |-> rem_r < dem_r)
    else $error("division remainder not reduced");

endmodule
